FILE: rtl/spae_pkg.sv
// ----------------------------------------------------------------------------
// spae_pkg
// Types and constants shared by the sparse polynomial add/evaluate unit.
// ----------------------------------------------------------------------------
package spae_pkg;

    localparam int COEFF_W = 32;
    localparam int EXP_W   = 8;

    localparam logic [EXP_W-1:0] MAX_EXPONENT = 8'd255;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [1:0] {
        ACT_LOAD_A = 2'd0,
        ACT_LOAD_B = 2'd1,
        ACT_ADD    = 2'd2,
        ACT_EVAL   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_TERM  = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_ACK   = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_ACK,
        ST_MRG_RD,
        ST_MRG_CMP,
        ST_ADD_EMPTY,
        ST_EV_RD,
        ST_EV_GO,
        ST_EV_WAIT,
        ST_EV_OUT
    } t_state;

    typedef struct packed {
        logic               start;
        logic [COEFF_W-1:0] coeff;
        logic [COEFF_W-1:0] base;
        logic [EXP_W-1:0]   exponent;
    } t_term_req;

    typedef struct packed {
        logic               done;
        logic [COEFF_W-1:0] product;
    } t_term_rsp;

endpackage

FILE: rtl/spae_term_mac.sv
// ----------------------------------------------------------------------------
// spae_term_mac
// Computes coeff * base^exponent with 32-bit wrap by square and multiply,
// one shared multiplier, one multiply per cycle.
// ----------------------------------------------------------------------------
module spae_term_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spae_pkg::t_term_req i_req,
    output spae_pkg::t_term_rsp o_rsp
);
    import spae_pkg::*;

    logic               r_busy;
    logic               r_phase;
    logic [COEFF_W-1:0] r_res;
    logic [COEFF_W-1:0] r_base;
    logic [EXP_W-1:0]   r_exp;
    logic [COEFF_W-1:0] mul_a;
    logic [COEFF_W-1:0] mul_p;
    logic               done;

    assign mul_a = r_phase ? r_base : r_res;
    assign mul_p = COEFF_W'(mul_a * r_base);
    assign done  = r_busy && (r_exp == '0);

    assign o_rsp.done    = done;
    assign o_rsp.product = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_res   <= i_req.coeff;
            r_base  <= i_req.base;
            r_exp   <= i_req.exponent;
            r_phase <= 1'b0;
        end else if (r_busy && !done) begin
            if (!r_phase) begin
                if (r_exp[0]) begin
                    r_res <= mul_p;
                end
                r_phase <= 1'b1;
            end else begin
                r_base  <= mul_p;
                r_exp   <= r_exp >> 1;
                r_phase <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/sparse_polynomial_add_evaluate_unit.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_add_evaluate_unit
// Loads two sparse term lists, merges them by exponent into a sum list and
// evaluates the sum list at a point, the term lists held in synchronous memories.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------
//  command  | in        | i_valid / o_stall  | action, new_list, term, x_value
//  result   | out       | o_valid / i_stall  | kind, status, term, value, last
//
//  Add: one transaction per sum term, or a single termless one for an empty sum;
//  each merge step waits on the registered list memory read.
//  Evaluate: the sum terms are taken in turn, each product computed by square and
//  multiply on the single shared multiplier.
//  Reset clears list counts and state; memories need no clearing pass.
//  A stalled result holds the unit in its current step.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_evaluate_unit #(
    parameter int MAX_TERMS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_action,
    input  logic                         i_new_list,
    input  logic signed [spae_pkg::COEFF_W-1:0] i_term_coeff,
    input  logic [spae_pkg::EXP_W-1:0]   i_term_exponent,
    input  logic signed [spae_pkg::COEFF_W-1:0] i_x_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_kind,
    output logic                         o_status,
    output logic                         o_term_valid,
    output logic signed [spae_pkg::COEFF_W-1:0] o_sum_coeff,
    output logic [spae_pkg::EXP_W-1:0]   o_sum_exponent,
    output logic signed [spae_pkg::COEFF_W-1:0] o_value,
    output logic                         o_last
);
    import spae_pkg::*;

    localparam int CW  = $clog2(MAX_TERMS + 1);
    localparam int AW  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int SD  = 2 * MAX_TERMS;
    localparam int SAW = $clog2(SD);
    localparam int SCW = $clog2(SD + 1);
    localparam int DW  = COEFF_W + EXP_W;
    localparam logic [CW-1:0]  MAX_CNT = CW'(MAX_TERMS);
    localparam logic [SCW-1:0] MAX_SUM = SCW'(SD);

    t_state r_state, n_state;
    t_action act;

    logic [CW-1:0]  r_cnt_a, r_cnt_b, r_i, r_j;
    logic [SCW-1:0] r_sum_cnt, r_k;

    logic [DW-1:0] mem_a [MAX_TERMS];
    logic [DW-1:0] mem_b [MAX_TERMS];
    logic [DW-1:0] mem_c [SD];
    logic [DW-1:0] r_a_rd, r_b_rd, r_c_rd;

    logic [COEFF_W-1:0] r_x, r_acc;
    logic               r_status;

    logic               r_out_valid, r_out_status, r_out_tvalid, r_out_last;
    t_kind              r_out_kind;
    logic [COEFF_W-1:0] r_out_coeff, r_out_value;
    logic [EXP_W-1:0]   r_out_exp;

    logic               out_load, n_out_status, n_out_tvalid, n_out_last;
    t_kind              n_out_kind;
    logic [COEFF_W-1:0] n_out_coeff, n_out_value;
    logic [EXP_W-1:0]   n_out_exp;

    logic               in_acc, out_free, a_we, b_we, c_we;
    logic [EXP_W-1:0]   exp_sat;
    logic [CW-1:0]      load_base;
    logic               load_fits;
    logic               a_ok, b_ok, same, take_a, mrg_last;
    logic [EXP_W-1:0]   ea, eb, mrg_exp;
    logic [COEFF_W-1:0] ca, cb, mrg_coeff;
    logic [CW-1:0]      nxt_i, nxt_j;
    logic               ev_start;

    t_term_req term_req;
    t_term_rsp term_rsp;

    spae_term_mac u_term_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (term_req),
        .o_rsp   (term_rsp)
    );

    assign act       = t_action'(i_action);
    assign in_acc    = i_valid && (r_state == ST_IDLE);
    assign out_free  = !r_out_valid || !i_stall;
    assign exp_sat   = (i_term_exponent > MAX_EXPONENT) ? MAX_EXPONENT : i_term_exponent;
    assign load_base = i_new_list ? '0 : ((act == ACT_LOAD_A) ? r_cnt_a : r_cnt_b);
    assign load_fits = load_base < MAX_CNT;

    assign ea = r_a_rd[EXP_W-1:0];
    assign eb = r_b_rd[EXP_W-1:0];
    assign ca = r_a_rd[DW-1:EXP_W];
    assign cb = r_b_rd[DW-1:EXP_W];

    assign a_ok      = r_i < r_cnt_a;
    assign b_ok      = r_j < r_cnt_b;
    assign same      = a_ok && b_ok && (ea == eb);
    assign take_a    = !b_ok || (a_ok && (ea > eb));
    assign mrg_coeff = same ? (ca + cb) : (take_a ? ca : cb);
    assign mrg_exp   = (same || take_a) ? ea : eb;
    assign nxt_i     = r_i + CW'(same || take_a);
    assign nxt_j     = r_j + CW'(same || !take_a);
    assign mrg_last  = (nxt_i >= r_cnt_a) && (nxt_j >= r_cnt_b);

    assign term_req.start    = ev_start;
    assign term_req.coeff    = r_c_rd[DW-1:EXP_W];
    assign term_req.exponent = r_c_rd[EXP_W-1:0];
    assign term_req.base     = r_x;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (act) inside
                        ACT_LOAD_A, ACT_LOAD_B: n_state = ST_LOAD_ACK;
                        ACT_ADD:                n_state = ST_MRG_RD;
                        ACT_EVAL:               n_state = ST_EV_RD;
                        default:                n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD_ACK: begin
                if (out_free) n_state = ST_IDLE;
            end
            ST_MRG_RD: begin
                n_state = (!a_ok && !b_ok) ? ST_ADD_EMPTY : ST_MRG_CMP;
            end
            ST_MRG_CMP: begin
                if (out_free) n_state = mrg_last ? ST_IDLE : ST_MRG_RD;
            end
            ST_ADD_EMPTY: begin
                if (out_free) n_state = ST_IDLE;
            end
            ST_EV_RD: begin
                n_state = (r_k == r_sum_cnt) ? ST_EV_OUT : ST_EV_GO;
            end
            ST_EV_GO: begin
                n_state = ST_EV_WAIT;
            end
            ST_EV_WAIT: begin
                if (term_rsp.done) n_state = ST_EV_RD;
            end
            ST_EV_OUT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall        = (r_state != ST_IDLE);
        a_we           = 1'b0;
        b_we           = 1'b0;
        c_we           = 1'b0;
        ev_start       = 1'b0;
        out_load       = 1'b0;
        n_out_kind     = KIND_TERM;
        n_out_status   = STATUS_OK;
        n_out_tvalid   = 1'b0;
        n_out_coeff    = '0;
        n_out_exp      = '0;
        n_out_value    = '0;
        n_out_last     = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                a_we = in_acc && (act == ACT_LOAD_A) && load_fits;
                b_we = in_acc && (act == ACT_LOAD_B) && load_fits;
            end
            ST_LOAD_ACK: begin
                out_load     = out_free;
                n_out_kind   = KIND_ACK;
                n_out_status = r_status;
            end
            ST_MRG_CMP: begin
                out_load     = out_free;
                c_we         = out_free;
                n_out_tvalid = 1'b1;
                n_out_coeff  = mrg_coeff;
                n_out_exp    = mrg_exp;
                n_out_last   = mrg_last;
            end
            ST_ADD_EMPTY: begin
                out_load = out_free;
            end
            ST_EV_GO: begin
                ev_start = 1'b1;
            end
            ST_EV_OUT: begin
                out_load    = out_free;
                n_out_kind  = KIND_VALUE;
                n_out_value = r_acc;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (a_we) begin
            mem_a[load_base[AW-1:0]] <= {i_term_coeff, exp_sat};
        end
        r_a_rd <= mem_a[r_i[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            mem_b[load_base[AW-1:0]] <= {i_term_coeff, exp_sat};
        end
        r_b_rd <= mem_b[r_j[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            mem_c[r_sum_cnt[SAW-1:0]] <= {mrg_coeff, mrg_exp};
        end
        r_c_rd <= mem_c[r_k[SAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_sum_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc && (act == ACT_LOAD_A)) begin
                r_cnt_a <= load_fits ? load_base + CW'(1) : load_base;
            end
            if (in_acc && (act == ACT_LOAD_B)) begin
                r_cnt_b <= load_fits ? load_base + CW'(1) : load_base;
            end
            if (in_acc && (act == ACT_ADD)) begin
                r_sum_cnt <= '0;
            end else if (c_we) begin
                r_sum_cnt <= r_sum_cnt + SCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status <= !load_fits;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_acc    <= '0;
            r_x      <= i_x_value;
        end else if (c_we) begin
            r_i <= nxt_i;
            r_j <= nxt_j;
        end else if ((r_state == ST_EV_WAIT) && term_rsp.done) begin
            r_acc <= r_acc + term_rsp.product;
            r_k   <= r_k + SCW'(1);
        end
        if (out_load) begin
            r_out_kind   <= n_out_kind;
            r_out_status <= n_out_status;
            r_out_tvalid <= n_out_tvalid;
            r_out_coeff  <= n_out_coeff;
            r_out_exp    <= n_out_exp;
            r_out_value  <= n_out_value;
            r_out_last   <= n_out_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_status       = r_out_status;
    assign o_term_valid   = r_out_tvalid;
    assign o_sum_coeff    = r_out_coeff;
    assign o_sum_exponent = r_out_exp;
    assign o_value        = r_out_value;
    assign o_last         = r_out_last;

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= MAX_CNT) && (r_cnt_b <= MAX_CNT) && (r_sum_cnt <= MAX_SUM))
        else $error("list count beyond capacity");

    a_merge_has_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MRG_CMP) |-> (a_ok || b_ok))
        else $error("merge step with both lists exhausted");

    a_mac_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        term_rsp.done |-> (r_state == ST_EV_WAIT))
        else $error("term product finished outside evaluation wait");

endmodule

FILE: tb/sparse_polynomial_add_evaluate_checker.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_add_evaluate_checker
// Watches the command and result channels of the sparse polynomial unit,
// keeps its own copy of lists A, B and the sum list, works out the results of
// every accepted command and compares each accepted result, field by field,
// with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_evaluate_checker #(
    parameter int MAX_TERMS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    input  logic                         i_cmd_stall,
    input  logic [1:0]                   i_action,
    input  logic                         i_new_list,
    input  logic [spae_pkg::COEFF_W-1:0] i_term_coeff,
    input  logic [spae_pkg::EXP_W-1:0]   i_term_exponent,
    input  logic [spae_pkg::COEFF_W-1:0] i_x_value,
    input  logic                         i_res_valid,
    input  logic                         i_res_stall,
    input  logic [1:0]                   i_kind,
    input  logic                         i_status,
    input  logic                         i_term_valid,
    input  logic [spae_pkg::COEFF_W-1:0] i_sum_coeff,
    input  logic [spae_pkg::EXP_W-1:0]   i_sum_exponent,
    input  logic [spae_pkg::COEFF_W-1:0] i_value,
    input  logic                         i_last,
    output int                           o_error_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import spae_pkg::*;

    localparam int SUM_DEPTH = 2 * MAX_TERMS;

    typedef struct {
        t_kind              kind;
        logic               status;
        logic               term_valid;
        logic [COEFF_W-1:0] coeff;
        logic [EXP_W-1:0]   exponent;
        logic [COEFF_W-1:0] value;
        logic               last;
    } t_outcome;

    logic [COEFF_W-1:0] list_coeff [2][MAX_TERMS];
    logic [EXP_W-1:0]   list_exponent [2][MAX_TERMS];
    int                 list_count [2];
    logic [COEFF_W-1:0] sum_coeff [SUM_DEPTH];
    logic [EXP_W-1:0]   sum_exponent [SUM_DEPTH];
    int                 sum_count;
    t_outcome           expected_outcomes [$];
    int                 mismatches;

    initial begin
        list_count[0] = 0;
        list_count[1] = 0;
        sum_count     = 0;
        mismatches    = 0;
    end

    function automatic logic [COEFF_W-1:0] power_wrapped(logic [COEFF_W-1:0] base,
                                                         logic [EXP_W-1:0] exponent);
        logic [COEFF_W-1:0] acc;
        logic [COEFF_W-1:0] square;
        acc    = 1;
        square = base;
        for (int b = 0; b < EXP_W; b++) begin
            if (exponent[b]) begin
                acc = acc * square;
            end
            square = square * square;
        end
        return acc;
    endfunction

    function automatic void expect_outcome(t_kind kind, logic status, logic term_valid,
                                           logic [COEFF_W-1:0] coeff,
                                           logic [EXP_W-1:0] exponent,
                                           logic [COEFF_W-1:0] value, logic last);
        t_outcome o;
        o.kind       = kind;
        o.status     = status;
        o.term_valid = term_valid;
        o.coeff      = coeff;
        o.exponent   = exponent;
        o.value      = value;
        o.last       = last;
        expected_outcomes.push_back(o);
    endfunction

    function automatic void store_sum_term(logic [COEFF_W-1:0] coeff,
                                           logic [EXP_W-1:0] exponent);
        if (sum_count < SUM_DEPTH) begin
            sum_coeff[sum_count]    = coeff;
            sum_exponent[sum_count] = exponent;
            sum_count++;
        end
    endfunction

    task automatic predict_command(t_action action, logic fresh, logic [COEFF_W-1:0] coeff,
                                   logic [EXP_W-1:0] exponent, logic [COEFF_W-1:0] x);
        int                 sel;
        int                 ia;
        int                 ib;
        logic [COEFF_W-1:0] acc;
        case (action)
            ACT_LOAD_A, ACT_LOAD_B: begin
                sel = int'(action == ACT_LOAD_B);
                if (fresh) begin
                    list_count[sel] = 0;
                end
                if (list_count[sel] < MAX_TERMS) begin
                    list_coeff[sel][list_count[sel]]    = coeff;
                    list_exponent[sel][list_count[sel]] =
                        (exponent > MAX_EXPONENT) ? MAX_EXPONENT : exponent;
                    list_count[sel]++;
                    expect_outcome(KIND_ACK, STATUS_OK, 1'b0, '0, '0, '0, 1'b1);
                end else begin
                    expect_outcome(KIND_ACK, STATUS_FULL, 1'b0, '0, '0, '0, 1'b1);
                end
            end
            ACT_ADD: begin
                ia        = 0;
                ib        = 0;
                sum_count = 0;
                while (ia < list_count[0] || ib < list_count[1]) begin
                    if (ia < list_count[0] && ib < list_count[1] &&
                        list_exponent[0][ia] == list_exponent[1][ib]) begin
                        store_sum_term(list_coeff[0][ia] + list_coeff[1][ib],
                                       list_exponent[0][ia]);
                        ia++;
                        ib++;
                    end else if (ib >= list_count[1] ||
                                 (ia < list_count[0] &&
                                  list_exponent[0][ia] > list_exponent[1][ib])) begin
                        store_sum_term(list_coeff[0][ia], list_exponent[0][ia]);
                        ia++;
                    end else begin
                        store_sum_term(list_coeff[1][ib], list_exponent[1][ib]);
                        ib++;
                    end
                end
                if (sum_count == 0) begin
                    expect_outcome(KIND_TERM, STATUS_OK, 1'b0, '0, '0, '0, 1'b1);
                end
                for (int k = 0; k < sum_count; k++) begin
                    expect_outcome(KIND_TERM, STATUS_OK, 1'b1, sum_coeff[k], sum_exponent[k],
                                   '0, k + 1 == sum_count);
                end
            end
            ACT_EVAL: begin
                acc = '0;
                for (int k = 0; k < sum_count; k++) begin
                    acc = acc + sum_coeff[k] * power_wrapped(x, sum_exponent[k]);
                end
                expect_outcome(KIND_VALUE, STATUS_OK, 1'b0, '0, '0, acc, 1'b1);
            end
        endcase
    endtask

    task automatic check_outcome();
        t_outcome want;
        if (expected_outcomes.size() == 0) begin
            if (mismatches < 10) begin
                $display("%0t: unexpected result kind %0d coeff %h exponent %0d value %h",
                         $realtime, i_kind, i_sum_coeff, i_sum_exponent, i_value);
            end
            mismatches++;
        end else begin
            want = expected_outcomes.pop_front();
            if (i_kind !== want.kind || i_status !== want.status ||
                i_term_valid !== want.term_valid || i_sum_coeff !== want.coeff ||
                i_sum_exponent !== want.exponent || i_value !== want.value ||
                i_last !== want.last) begin
                if (mismatches < 10) begin
                    $display("%0t: result mismatch (expected/actual) kind %0d/%0d",
                             $realtime, want.kind, i_kind);
                    $display("    status %0d/%0d term_valid %0d/%0d coeff %h/%h",
                             want.status, i_status, want.term_valid, i_term_valid,
                             want.coeff, i_sum_coeff);
                    $display("    exponent %0d/%0d value %h/%h last %0d/%0d",
                             want.exponent, i_sum_exponent, want.value, i_value,
                             want.last, i_last);
                end
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_cmd_valid && !i_cmd_stall) begin
            predict_command(t_action'(i_action), i_new_list, i_term_coeff, i_term_exponent,
                            i_x_value);
        end
        if (i_rst_n && i_res_valid && !i_res_stall) begin
            check_outcome();
        end
        o_error_count <= mismatches;
        o_pending     <= expected_outcomes.size();
    end

endmodule

FILE: tb/sparse_polynomial_add_evaluate_unit_tb.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_add_evaluate_unit_tb
// Drives load, add and evaluate commands into the sparse polynomial unit: a
// directed opening over the corner cases, then random list loads followed by
// add and evaluate, mixed with stray commands. Both channels idle at random,
// and the result side holds off once for a long stretch. The checker beside
// the unit predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_evaluate_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spae_pkg::*;

    localparam int TARGET_ITEMS = 310;
    localparam int MAX_GAP      = 17;
    localparam int HOLD_AFTER   = 40;
    localparam int HOLD_CYCLES  = 600;
    localparam int IDLE_LIMIT   = 8000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_action;
    logic               i_new_list;
    logic [COEFF_W-1:0] i_term_coeff;
    logic [EXP_W-1:0]   i_term_exponent;
    logic [COEFF_W-1:0] i_x_value;
    logic               o_valid;
    logic               i_stall;
    logic [1:0]         o_kind;
    logic               o_status;
    logic               o_term_valid;
    logic [COEFF_W-1:0] o_sum_coeff;
    logic [EXP_W-1:0]   o_sum_exponent;
    logic [COEFF_W-1:0] o_value;
    logic               o_last;

    int error_count;
    int outcomes_pending;
    int commands_issued;

    sparse_polynomial_add_evaluate_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_action        (i_action),
        .i_new_list      (i_new_list),
        .i_term_coeff    (i_term_coeff),
        .i_term_exponent (i_term_exponent),
        .i_x_value       (i_x_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_status        (o_status),
        .o_term_valid    (o_term_valid),
        .o_sum_coeff     (o_sum_coeff),
        .o_sum_exponent  (o_sum_exponent),
        .o_value         (o_value),
        .o_last          (o_last)
    );

    sparse_polynomial_add_evaluate_checker result_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (i_valid),
        .i_cmd_stall     (o_stall),
        .i_action        (i_action),
        .i_new_list      (i_new_list),
        .i_term_coeff    (i_term_coeff),
        .i_term_exponent (i_term_exponent),
        .i_x_value       (i_x_value),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_kind          (o_kind),
        .i_status        (o_status),
        .i_term_valid    (o_term_valid),
        .i_sum_coeff     (o_sum_coeff),
        .i_sum_exponent  (o_sum_exponent),
        .i_value         (o_value),
        .i_last          (o_last),
        .o_error_count   (error_count),
        .o_pending       (outcomes_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : result_sink
        int gap;
        int taken;
        bit held;
        taken   = 0;
        held    = 1'b0;
        i_stall = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!held && taken == HOLD_AFTER) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end else begin
                gap = (((taken / 29) % 3) == 1) ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
                i_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            taken++;
            @(negedge i_clk);
        end
    end

    function automatic logic [COEFF_W-1:0] random_coeff();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [COEFF_W-1:0] random_point();
        if ($urandom_range(0, 2) == 0) begin
            return $urandom;
        end
        return $urandom_range(0, 8) - 4;
    endfunction

    function automatic logic [EXP_W-1:0] random_exponent();
        return EXP_W'($urandom);
    endfunction

    task automatic issue_command(t_action action, logic fresh, logic [COEFF_W-1:0] coeff,
                                 logic [EXP_W-1:0] exponent, logic [COEFF_W-1:0] x);
        int gap;
        gap = (((commands_issued / 37) % 3) == 2) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_action        <= action;
        i_new_list      <= fresh;
        i_term_coeff    <= coeff;
        i_term_exponent <= exponent;
        i_x_value       <= x;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        commands_issued++;
        @(negedge i_clk);
    endtask

    task automatic load_terms(t_action target, int n, bit wide);
        int e;
        e = wide ? $urandom_range(70, 255) : $urandom_range(0, 20);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                e = $urandom_range(0, 255);
            end
            issue_command(target, k == 0, random_coeff(), e[EXP_W-1:0], $urandom);
            e = (e > 2) ? e - int'($urandom_range(1, 2)) : 0;
        end
    endtask

    initial begin : stimulus
        int  seq;
        int  na;
        int  nb;
        bit  wide;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_action        = ACT_LOAD_A;
        i_new_list      = 1'b0;
        i_term_coeff    = '0;
        i_term_exponent = '0;
        i_x_value       = '0;
        commands_issued = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        issue_command(ACT_EVAL, 1'b0, $urandom, random_exponent(), $urandom);
        issue_command(ACT_ADD, 1'b1, $urandom, random_exponent(), $urandom);
        issue_command(ACT_LOAD_A, 1'b1, 32'h7FFF_FFFF, 8'd255, $urandom);
        issue_command(ACT_LOAD_A, 1'b0, 32'h8000_0000, 8'd128, $urandom);
        issue_command(ACT_LOAD_A, 1'b0, 32'd1, 8'd0, $urandom);
        issue_command(ACT_LOAD_B, 1'b1, 32'h8000_0001, 8'd255, $urandom);
        issue_command(ACT_LOAD_B, 1'b0, 32'hFFFF_FFFF, 8'd200, $urandom);
        issue_command(ACT_LOAD_B, 1'b0, 32'hFFFF_FFFF, 8'd128, $urandom);
        issue_command(ACT_ADD, 1'b0, $urandom, random_exponent(), $urandom);
        issue_command(ACT_EVAL, 1'b1, $urandom, random_exponent(), 32'd0);
        issue_command(ACT_EVAL, 1'b0, $urandom, random_exponent(), 32'hFFFF_FFFF);
        issue_command(ACT_EVAL, 1'b0, $urandom, random_exponent(), 32'h8000_0000);
        issue_command(ACT_EVAL, 1'b0, $urandom, random_exponent(), 32'h7FFF_FFFF);
        issue_command(ACT_LOAD_A, 1'b1, $urandom, 8'd3, $urandom);
        issue_command(ACT_EVAL, 1'b0, $urandom, random_exponent(), 32'd2);
        issue_command(ACT_LOAD_B, 1'b1, $urandom, 8'd10, $urandom);
        issue_command(ACT_LOAD_B, 1'b0, $urandom, 8'd20, $urandom);
        issue_command(ACT_LOAD_B, 1'b0, $urandom, 8'd10, $urandom);
        issue_command(ACT_LOAD_A, 1'b0, 32'd5, 8'd10, $urandom);
        issue_command(ACT_ADD, 1'b1, $urandom, random_exponent(), $urandom);
        issue_command(ACT_EVAL, 1'b1, $urandom, random_exponent(), 32'd3);

        seq = 0;
        while (commands_issued < TARGET_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    issue_command(t_action'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                  random_coeff(), random_exponent(), random_point());
                end
            end else begin
                wide = (seq == 0) || ($urandom_range(0, 9) == 0);
                na   = (seq == 0) ? 34 : wide ? $urandom_range(28, 34) : $urandom_range(0, 6);
                nb   = wide ? $urandom_range(30, 34) : $urandom_range(0, 6);
                load_terms(ACT_LOAD_A, na, wide);
                load_terms(ACT_LOAD_B, nb, wide);
                issue_command(ACT_ADD, 1'($urandom_range(0, 1)), $urandom, random_exponent(),
                              $urandom);
                repeat ($urandom_range(1, 3)) begin
                    issue_command(ACT_EVAL, 1'($urandom_range(0, 1)), $urandom,
                                  random_exponent(), random_point());
                end
                seq++;
            end
        end
        i_valid <= 1'b0;

        wait (outcomes_pending == 0);
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && outcomes_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
